[hw/rtl/vrtc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vrtc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_VIEW_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_VIEW_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_REGION_0     = 3'd2;
    localparam logic [2:0] CFG_REGION_1     = 3'd3;
    localparam logic [2:0] CFG_REGION_2     = 3'd4;
    localparam logic [2:0] CFG_REGION_3     = 3'd5;
    localparam logic [2:0] CFG_REGION_COUNT = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Input commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_HOME   = 1'b1;

    // Region as packed in its configuration register
    typedef struct packed {
        logic [15:0] height;
        logic [15:0] width;
        logic [15:0] bottom;
        logic [15:0] left;
    } region_t;

    // Reset values
    localparam logic [15:0] VIEW_WIDTH_RST   = 16'd304;
    localparam logic [15:0] VIEW_HEIGHT_RST  = 16'd224;
    localparam region_t     REGION_ZERO_RST  = '{height: 16'd224, width: 16'd3480,
                                                 bottom: 16'd0, left: 16'd0};
    localparam region_t     REGION_OTHER_RST = '0;
    localparam logic [2:0]  REGION_COUNT_RST = 3'd1;

endpackage

`default_nettype wire

[hw/rtl/vrtc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface vrtc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] target_left;
    logic [15:0] target_bottom;
    logic [15:0] target_width;
    logic [15:0] target_height;

    modport source (
        output valid, command, target_left, target_bottom, target_width, target_height,
        input  ready
    );
    modport sink (
        input  valid, command, target_left, target_bottom, target_width, target_height,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/vrtc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface vrtc_out_if;
    logic        valid;
    logic        ready;
    logic [17:0] view_x_half;
    logic [17:0] view_y_half;
    logic [1:0]  region_index;

    modport source (
        output valid, view_x_half, view_y_half, region_index,
        input  ready
    );
    modport sink (
        input  valid, view_x_half, view_y_half, region_index,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/viewport_region_track_clamp.sv]
// Viewport region tracker. Each input word carries a target rectangle and a command.
// An update searches the enabled regions from the highest index down (enabled: index
// below region_count and region at least as large as the view) and makes the first one
// that wholly contains the target current; a home command sets region 0 without a
// search. A view of the configured size is then centered on the target and clamped to
// the current region, right/top limit first, left/bottom edge last, and the corner is
// returned in half pixels with the region index. All size, edge and clamp arithmetic
// runs through a single add/subtract/compare unit under a small sequencer, one
// operation per cycle, and the block takes no new word while it works. An update
// first searches: per region index a count check, then compares of size vs. view and
// of each edge, stopping early at the first failed compare or at a hit.
// A result waiting at the output does not block the next word; only the final load
// into the output register waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module viewport_region_track_clamp
    import vrtc_pkg::*;
#(
    parameter int MAX_REGIONS = 4
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire [CFG_INDEX_W-1:0]        cfg_index,
    input  wire [CFG_DATA_W-1:0]         cfg_data,
    vrtc_in_if.sink                      in_ch,
    vrtc_out_if.source                   out_ch
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [1:0] TOP_IDX = 2'(MAX_REGIONS - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_VW   = 4'd2;
    localparam logic [3:0] S_VH   = 4'd3;
    localparam logic [3:0] S_X1   = 4'd4;
    localparam logic [3:0] S_X0   = 4'd5;
    localparam logic [3:0] S_Y1   = 4'd6;
    localparam logic [3:0] S_Y0   = 4'd7;
    localparam logic [3:0] S_P    = 4'd8;
    localparam logic [3:0] S_HI   = 4'd9;
    localparam logic [3:0] S_CHI  = 4'd10;
    localparam logic [3:0] S_CLO  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    function automatic logic signed [19:0] ext1(input logic [15:0] v);
        return signed'({4'b0000, v});
    endfunction

    function automatic logic signed [19:0] ext2(input logic [15:0] v);
        return signed'({3'b000, v, 1'b0});
    endfunction

    // Configuration registers
    logic [15:0] view_w_reg;
    logic [15:0] view_h_reg;
    region_t     region_reg [MAX_REGIONS];
    logic [2:0]  count_reg;

    // Sequencer and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         cur_reg, cur_next;
    logic               axis_reg, axis_next;
    logic signed [19:0] acc_reg, acc_next;
    logic signed [19:0] hi_reg, hi_next;
    logic [17:0]        x_reg, x_next;
    logic [17:0]        y_reg, y_next;
    logic [15:0]        tl_reg, tb_reg, tw_reg, th_reg;
    logic               out_valid_reg;
    logic [17:0]        out_x_reg, out_y_reg;
    logic [1:0]         out_idx_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_w_reg <= VIEW_WIDTH_RST;
            view_h_reg <= VIEW_HEIGHT_RST;
            count_reg  <= REGION_COUNT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_VIEW_WIDTH)
                view_w_reg <= cfg_data[15:0];
            if (cfg_index == CFG_VIEW_HEIGHT)
                view_h_reg <= cfg_data[15:0];
            if (cfg_index == CFG_REGION_COUNT)
                count_reg <= cfg_data[2:0];
        end
    end

    for (genvar g = 0; g < MAX_REGIONS; g++)
    begin : g_region
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                region_reg[g] <= (g == 0) ? REGION_ZERO_RST : REGION_OTHER_RST;
            else if (cfg_we && (cfg_index == CFG_REGION_0 + CFG_INDEX_W'(g)))
                region_reg[g] <= region_t'(cfg_data);
        end
    end

    // Selected region and axis operands
    region_t     reg_sel;
    logic [15:0] t_pos, t_size, v_size, r_pos, r_size;

    always_comb
    begin
        reg_sel = region_reg[idx_reg[IDX_W-1:0]];
        t_pos   = axis_reg ? tb_reg : tl_reg;
        t_size  = axis_reg ? th_reg : tw_reg;
        v_size  = axis_reg ? view_h_reg : view_w_reg;
        r_pos   = axis_reg ? reg_sel.bottom : reg_sel.left;
        r_size  = axis_reg ? reg_sel.height : reg_sel.width;
    end

    // Shared unit: diff = a + b - c - e, gt = diff > 0
    logic signed [19:0] op_a, op_b, op_c, op_e, alu_diff;
    logic               alu_gt;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
        op_e = '0;
        unique case (state_reg)
            S_VW:
            begin
                op_a = ext1(view_w_reg);
                op_c = ext1(reg_sel.width);
            end
            S_VH:
            begin
                op_a = ext1(view_h_reg);
                op_c = ext1(reg_sel.height);
            end
            S_X1:
            begin
                op_a = ext1(tl_reg);
                op_b = ext1(tw_reg);
                op_c = ext1(reg_sel.left);
                op_e = ext1(reg_sel.width);
            end
            S_X0:
            begin
                op_a = ext1(reg_sel.left);
                op_c = ext1(tl_reg);
            end
            S_Y1:
            begin
                op_a = ext1(tb_reg);
                op_b = ext1(th_reg);
                op_c = ext1(reg_sel.bottom);
                op_e = ext1(reg_sel.height);
            end
            S_Y0:
            begin
                op_a = ext1(reg_sel.bottom);
                op_c = ext1(tb_reg);
            end
            S_P:
            begin
                op_a = ext2(t_pos);
                op_b = ext1(t_size);
                op_c = ext1(v_size);
            end
            S_HI:
            begin
                op_a = ext2(r_pos);
                op_b = ext2(r_size);
                op_c = ext2(v_size);
            end
            S_CHI:
            begin
                op_a = acc_reg;
                op_c = hi_reg;
            end
            S_CLO:
            begin
                op_a = ext2(r_pos);
                op_c = acc_reg;
            end
            default:
            begin
            end
        endcase
        alu_diff = op_a + op_b - op_c - op_e;
        alu_gt   = (alu_diff > 20'sd0);
    end

    logic in_acc, out_free;
    logic signed [19:0] final_val;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign final_val = alu_gt ? ext2(r_pos) : acc_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        axis_next  = axis_reg;
        acc_next   = acc_reg;
        hi_next    = hi_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    axis_next = 1'b0;
                    if (in_ch.command == CMD_HOME)
                    begin
                        cur_next   = 2'd0;
                        idx_next   = 2'd0;
                        state_next = S_P;
                    end
                    else
                    begin
                        idx_next   = TOP_IDX;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN, S_VW, S_VH, S_X1, S_X0, S_Y1, S_Y0:
            begin
                // Drop the region on a failed check, advance on a pass
                if ((state_reg == S_SCAN) ? ({1'b0, idx_reg} >= count_reg) : alu_gt)
                begin
                    if (idx_reg == 2'd0)
                    begin
                        idx_next   = cur_reg;
                        state_next = S_P;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 2'd1;
                        state_next = S_SCAN;
                    end
                end
                else if (state_reg == S_Y0)
                begin
                    cur_next   = idx_reg;
                    state_next = S_P;
                end
                else
                begin
                    state_next = state_reg + 4'd1;
                end
            end
            S_P:
            begin
                acc_next   = alu_diff;
                state_next = S_HI;
            end
            S_HI:
            begin
                hi_next    = alu_diff;
                state_next = S_CHI;
            end
            S_CHI:
            begin
                if (alu_gt)
                    acc_next = hi_reg;
                state_next = S_CLO;
            end
            S_CLO:
            begin
                if (axis_reg)
                begin
                    y_next     = final_val[17:0];
                    state_next = S_DONE;
                end
                else
                begin
                    x_next     = final_val[17:0];
                    axis_next  = 1'b1;
                    state_next = S_P;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= 2'd0;
            idx_reg   <= 2'd0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
        end
    end

    // Hold the target and working values
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        hi_reg  <= hi_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (in_acc)
        begin
            tl_reg <= in_ch.target_left;
            tb_reg <= in_ch.target_bottom;
            tw_reg <= in_ch.target_width;
            th_reg <= in_ch.target_height;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_DONE) && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            out_idx_reg <= cur_reg;
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.view_x_half  = out_x_reg;
    assign out_ch.view_y_half  = out_y_reg;
    assign out_ch.region_index = out_idx_reg;

`ifndef ASSERT_OFF
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word loaded outside the done step");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) < MAX_REGIONS)
        else $error("current region beyond the region array");

    a_check_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VW) |-> ({1'b0, idx_reg} < count_reg) && (32'(idx_reg) < MAX_REGIONS))
        else $error("size check on a region outside the count");

    a_home_sets_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.command == CMD_HOME)) |=> (cur_reg == 2'd0) && (state_reg == S_P))
        else $error("home command did not select region zero");
`endif

endmodule

`default_nettype wire
